// File: design/window_consistency_boost_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the window consistency boost unit
// Shorthand forms of the concurrent checks used in the design files.
// ----------------------------------------------------------------------------
`ifndef WINDOW_CONSISTENCY_BOOST_UNIT_MACROS_SVH
`define WINDOW_CONSISTENCY_BOOST_UNIT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define WCB_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define WCB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define WCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/wcb_pkg.sv
// ----------------------------------------------------------------------------
// wcb_pkg
// Widths, constants, types and helpers shared by the boost unit modules.
// ----------------------------------------------------------------------------
package wcb_pkg;

    localparam int MAX_COLS      = 1024;
    localparam int MAX_ROWS      = 4096;
    localparam int WINDOW_RADIUS = 4;
    localparam int AMP_W         = 16;

    localparam int WSIZE   = 2 * WINDOW_RADIUS + 1;
    localparam int NLINES  = 2 * WINDOW_RADIUS;
    localparam int LANE_W  = $clog2(NLINES);
    localparam int ADDR_W  = $clog2(MAX_COLS);

    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int CFG_WID_W  = 11;
    localparam int CFG_HGT_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Match counts: per window row, and over the whole window.
    localparam int ROWCNT_W = $clog2(WSIZE + 1);
    localparam int CNT_W    = $clog2(WSIZE * WSIZE + 1);
    localparam int PROD_W   = AMP_W + CNT_W;

    // Division by WSIZE*WSIZE as a multiply by a rounded-up reciprocal.
    // The shift is chosen so that the reciprocal's excess times the largest
    // product stays below 2**DIV_SHIFT, which keeps the quotient exact.
    localparam int          DIV_SHIFT = 27;
    localparam longint      DIV_NUM   = (longint'(1) << DIV_SHIFT) + WSIZE * WSIZE - 1;
    localparam longint      DIV_MUL   = DIV_NUM / (WSIZE * WSIZE);
    localparam int          MUL_W     = $clog2(DIV_MUL + 1);
    localparam int          SCALED_W  = PROD_W + MUL_W;

    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [NLINES-1:0][AMP_W-1:0]   t_line_word;
    typedef logic [WSIZE-1:0][ROWCNT_W-1:0] t_row_counts;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_meta;

    typedef struct packed {
        logic [AMP_W-1:0] boosted;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_result;

    // Number of set bits in one window row of match flags.
    function automatic logic [ROWCNT_W-1:0] count_row(input logic [WSIZE-1:0] hits);
        logic [ROWCNT_W-1:0] sum;
        sum = '0;
        for (int j = 0; j < WSIZE; j++) begin
            sum = sum + ROWCNT_W'(hits[j]);
        end
        return sum;
    endfunction

endpackage

// File: design/wcb_line_mem.sv
// ----------------------------------------------------------------------------
// wcb_line_mem
// Line store: one word per column holding that column of every stored line.
// ----------------------------------------------------------------------------
module wcb_line_mem (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [wcb_pkg::ADDR_W-1:0] i_addr,
    input  logic [wcb_pkg::LANE_W-1:0] i_lane,
    input  logic [wcb_pkg::AMP_W-1:0]  i_wr_data,
    output wcb_pkg::t_line_word        o_rd_word
);
    import wcb_pkg::*;

    t_line_word r_mem [MAX_COLS];
    t_line_word r_rd_word;

    // The read returns the column before the new pixel replaces its lane,
    // so the oldest line leaves the window as the newest one enters.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_word              <= r_mem[i_addr];
            r_mem[i_addr][i_lane]  <= i_wr_data;
        end
    end

    assign o_rd_word = r_rd_word;

endmodule

// File: design/wcb_window.sv
// ----------------------------------------------------------------------------
// wcb_window
// Sliding 9x9 pixel window with the centre comparison and per-row match counts.
// ----------------------------------------------------------------------------
module wcb_window (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s1_valid,
    input  wcb_pkg::t_meta             i_s1_meta,
    input  logic [wcb_pkg::LANE_W-1:0] i_s1_lane,
    input  logic [wcb_pkg::AMP_W-1:0]  i_s1_pix,
    input  wcb_pkg::t_line_word        i_line_word,
    output logic                       o_s3_valid,
    output wcb_pkg::t_meta             o_s3_meta,
    output logic [wcb_pkg::AMP_W-1:0]  o_s3_centre,
    output wcb_pkg::t_row_counts       o_s3_row_counts
);
    import wcb_pkg::*;

    logic [AMP_W-1:0] r_win [WSIZE][WSIZE];

    logic        r_s2_valid;
    t_meta       r_s2_meta;
    logic        r_s3_valid;
    t_meta       r_s3_meta;
    logic [AMP_W-1:0] r_s3_centre;
    t_row_counts r_s3_row_counts;
    t_row_counts n_row_counts;

    // Shift left and load the new column: stored lines oldest first, the
    // incoming pixel at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_s1_valid) begin
            for (int k = 0; k < WSIZE; k++) begin
                for (int j = 0; j < WSIZE - 1; j++) begin
                    r_win[k][j] <= r_win[k][j+1];
                end
            end
            for (int k = 0; k < NLINES; k++) begin
                r_win[k][WSIZE-1] <= i_line_word[i_s1_lane + LANE_W'(k)];
            end
            r_win[WSIZE-1][WSIZE-1] <= i_s1_pix;
        end
    end

    always_comb begin
        logic [WSIZE-1:0] hits;
        logic [AMP_W-1:0] centre;
        centre = r_win[WINDOW_RADIUS][WINDOW_RADIUS];
        for (int k = 0; k < WSIZE; k++) begin
            for (int j = 0; j < WSIZE; j++) begin
                hits[j] = ({r_win[k][j], 1'b0} >= {1'b0, centre}) &&
                          ({1'b0, r_win[k][j]} <= {centre, 1'b0});
            end
            n_row_counts[k] = count_row(hits);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_meta       <= i_s1_meta;
        r_s3_meta       <= r_s2_meta;
        r_s3_centre     <= r_win[WINDOW_RADIUS][WINDOW_RADIUS];
        r_s3_row_counts <= n_row_counts;
    end

    assign o_s3_valid      = r_s3_valid;
    assign o_s3_meta       = r_s3_meta;
    assign o_s3_centre     = r_s3_centre;
    assign o_s3_row_counts = r_s3_row_counts;

endmodule

// File: design/wcb_scale.sv
// ----------------------------------------------------------------------------
// wcb_scale
// Sums the row counts, multiplies by the centre and divides by the window area.
// ----------------------------------------------------------------------------
module wcb_scale (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s3_valid,
    input  wcb_pkg::t_meta            i_s3_meta,
    input  logic [wcb_pkg::AMP_W-1:0] i_s3_centre,
    input  wcb_pkg::t_row_counts      i_s3_row_counts,
    output logic                      o_valid,
    output wcb_pkg::t_meta            o_meta,
    output logic [wcb_pkg::AMP_W-1:0] o_boosted
);
    import wcb_pkg::*;

    localparam logic [MUL_W-1:0] DIV_MUL_C = MUL_W'(DIV_MUL);

    logic              r_s4_valid;
    t_meta             r_s4_meta;
    logic [AMP_W-1:0]  r_s4_centre;
    logic [CNT_W-1:0]  r_s4_cnt;
    logic              r_s5_valid;
    t_meta             r_s5_meta;
    logic [PROD_W-1:0] r_s5_prod;
    logic [CNT_W-1:0]  n_cnt;
    logic [SCALED_W-1:0] scaled;

    always_comb begin
        n_cnt = '0;
        for (int k = 0; k < WSIZE; k++) begin
            n_cnt = n_cnt + CNT_W'(i_s3_row_counts[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            r_s4_valid <= i_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    // A zero centre yields a zero product, so it needs no special path.
    always_ff @(posedge i_clk) begin
        r_s4_meta   <= i_s3_meta;
        r_s4_centre <= i_s3_centre;
        r_s4_cnt    <= n_cnt;
        r_s5_meta   <= r_s4_meta;
        r_s5_prod   <= PROD_W'(r_s4_centre) * PROD_W'(r_s4_cnt);
    end

    assign scaled    = SCALED_W'(r_s5_prod) * SCALED_W'(DIV_MUL_C);
    assign o_valid   = r_s5_valid;
    assign o_meta    = r_s5_meta;
    assign o_boosted = scaled[DIV_SHIFT +: AMP_W];

endmodule

// File: design/wcb_out_fifo.sv
// ----------------------------------------------------------------------------
// wcb_out_fifo
// Result queue between the free-running pipeline and the output channel.
// ----------------------------------------------------------------------------
module wcb_out_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  wcb_pkg::t_result               i_push_data,
    input  logic                           i_pop,
    output logic                           o_valid,
    output wcb_pkg::t_result               o_data,
    output logic [wcb_pkg::FIFO_CNT_W-1:0] o_count
);
    import wcb_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_wr_ptr;
    logic [FIFO_AW-1:0]    r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + FIFO_CNT_W'(i_push) - FIFO_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: design/window_consistency_boost_unit.sv
// ----------------------------------------------------------------------------
// window_consistency_boost_unit
// Local-consistency boost of an amplitude image over a 9x9 window.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on i_valid / o_ready, one item per pixel.
// For each pixel at least four from every edge, one result item leaves on
// o_valid / i_ready once the window around it is complete: the centre value
// times the number of matching window pixels, divided by 81 and rounded down,
// with its line and column and a flag on the last interior pixel. Border
// pixels produce no result.
// Throughput is one pixel per cycle while o_ready is high. The line store is a
// single memory with one word per column, read and lane-written once per pixel,
// which sets the rate. Results pass through window load, compare, sum, multiply
// and reciprocal scale. Results wait in a 16-item queue; o_ready drops only
// when the queue plus the items in flight would fill it, so a stalled receiver
// holds input back without losing anything. The user must write image width and
// height on the config port only while the unit is idle; the unit does not
// enforce it. Reset restores 640 x 480 and restarts at the first pixel; the
// line store is not cleared, since each line is written before it is read.
// ----------------------------------------------------------------------------
`include "window_consistency_boost_unit_macros.svh"

module window_consistency_boost_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wcb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wcb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [wcb_pkg::AMP_W-1:0]      i_amplitude,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [wcb_pkg::AMP_W-1:0]      o_boosted,
    output logic [wcb_pkg::ROW_W-1:0]      o_out_row,
    output logic [wcb_pkg::COL_W-1:0]      o_out_col,
    output logic                           o_last_pixel
);
    import wcb_pkg::*;

    logic [CFG_WID_W-1:0]  r_width;
    logic [CFG_HGT_W-1:0]  r_height;
    logic [CFG_WID_W-1:0]  n_width;
    logic [CFG_HGT_W-1:0]  n_height;
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      n_row;
    logic [COL_W-1:0]      n_col;
    logic [FIFO_CNT_W-1:0] r_outstanding;

    logic                  accept;
    logic                  pop;
    logic                  drop;
    logic                  push;
    t_meta                 cur_meta;

    logic                  r_s1_valid;
    t_meta                 r_s1_meta;
    logic [LANE_W-1:0]     r_s1_lane;
    logic [AMP_W-1:0]      r_s1_pix;

    t_line_word            line_word;
    logic                  s3_valid;
    t_meta                 s3_meta;
    logic [AMP_W-1:0]      s3_centre;
    t_row_counts           s3_row_counts;
    logic                  sc_valid;
    t_meta                 sc_meta;
    logic [AMP_W-1:0]      sc_boosted;
    t_result               push_data;
    t_result               head;
    logic [FIFO_CNT_W-1:0] fifo_count;

    // Configuration values are saturated into their legal ranges.
    always_comb begin
        logic [CFG_WID_W-1:0] wv;
        logic [CFG_HGT_W-1:0] hv;
        wv = i_cfg_data[CFG_WID_W-1:0];
        hv = i_cfg_data[CFG_HGT_W-1:0];
        if (wv < CFG_WID_W'(WSIZE)) begin
            n_width = CFG_WID_W'(WSIZE);
        end else if (wv > CFG_WID_W'(MAX_COLS)) begin
            n_width = CFG_WID_W'(MAX_COLS);
        end else begin
            n_width = wv;
        end
        if (hv < CFG_HGT_W'(WSIZE)) begin
            n_height = CFG_HGT_W'(WSIZE);
        end else if (hv > CFG_HGT_W'(MAX_ROWS)) begin
            n_height = CFG_HGT_W'(MAX_ROWS);
        end else begin
            n_height = hv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_WID_W'(RESET_WIDTH);
            r_height <= CFG_HGT_W'(RESET_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_WIDTH:  r_width  <= n_width;
                CFG_IDX_HEIGHT: r_height <= n_height;
                default: ;
            endcase
        end
    end

    assign accept = i_valid && o_ready;
    assign o_ready = (r_outstanding < FIFO_CNT_W'(FIFO_DEPTH));

    // Raster position of the incoming pixel and what it completes.
    always_comb begin
        cur_meta.emit = (r_row >= ROW_W'(NLINES)) && (r_col >= COL_W'(NLINES)) &&
                        ({1'b0, r_row} < r_height) && ({1'b0, r_col} < r_width);
        cur_meta.last = ({1'b0, r_row} == r_height - CFG_HGT_W'(1)) &&
                        ({1'b0, r_col} == r_width - CFG_WID_W'(1));
        cur_meta.row  = r_row - ROW_W'(WINDOW_RADIUS);
        cur_meta.col  = r_col - COL_W'(WINDOW_RADIUS);

        // Counters left beyond a smaller size by a config write wrap to zero.
        if (({1'b0, r_col} + CFG_WID_W'(1)) >= r_width) begin
            n_col = '0;
            if (({1'b0, r_row} + CFG_HGT_W'(1)) >= r_height) begin
                n_row = '0;
            end else begin
                n_row = r_row + ROW_W'(1);
            end
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_meta <= cur_meta;
            r_s1_lane <= r_row[LANE_W-1:0];
            r_s1_pix  <= i_amplitude;
        end
    end

    wcb_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_en      (accept),
        .i_addr    (r_col[ADDR_W-1:0]),
        .i_lane    (r_row[LANE_W-1:0]),
        .i_wr_data (i_amplitude),
        .o_rd_word (line_word)
    );

    wcb_window u_window (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s1_valid      (r_s1_valid),
        .i_s1_meta       (r_s1_meta),
        .i_s1_lane       (r_s1_lane),
        .i_s1_pix        (r_s1_pix),
        .i_line_word     (line_word),
        .o_s3_valid      (s3_valid),
        .o_s3_meta       (s3_meta),
        .o_s3_centre     (s3_centre),
        .o_s3_row_counts (s3_row_counts)
    );

    wcb_scale u_scale (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s3_valid      (s3_valid),
        .i_s3_meta       (s3_meta),
        .i_s3_centre     (s3_centre),
        .i_s3_row_counts (s3_row_counts),
        .o_valid         (sc_valid),
        .o_meta          (sc_meta),
        .o_boosted       (sc_boosted)
    );

    assign push = sc_valid && sc_meta.emit;
    assign drop = sc_valid && !sc_meta.emit;
    assign pop  = o_valid && i_ready;

    always_comb begin
        push_data.boosted = sc_boosted;
        push_data.row     = sc_meta.row;
        push_data.col     = sc_meta.col;
        push_data.last    = sc_meta.last;
    end

    wcb_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_valid     (o_valid),
        .o_data      (head),
        .o_count     (fifo_count)
    );

    // Items taken and not yet delivered or dropped; bounds the queue fill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + FIFO_CNT_W'(accept)
                           - FIFO_CNT_W'(pop) - FIFO_CNT_W'(drop);
        end
    end

    assign o_boosted    = head.boosted;
    assign o_out_row    = head.row;
    assign o_out_col    = head.col;
    assign o_last_pixel = head.last;

    `WCB_ASSERT_ALWAYS(a_credit_bound, i_clk, i_rst_n, r_outstanding <= FIFO_CNT_W'(FIFO_DEPTH), "outstanding items exceed the queue depth")
    `WCB_ASSERT_ALWAYS(a_queue_within_credit, i_clk, i_rst_n, fifo_count <= r_outstanding, "queue holds more items than were taken")
    `WCB_ASSERT_IMPLY(a_push_not_full, i_clk, i_rst_n, push, fifo_count < FIFO_CNT_W'(FIFO_DEPTH) || pop, "result pushed into a full queue")
    `WCB_ASSERT_NEXT(a_accept_counted, i_clk, i_rst_n, accept, r_outstanding != '0, "accepted item not counted as outstanding")

endmodule

// File: tb/window_consistency_boost_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window_consistency_boost_unit_tb
// Self-checking testbench for the 9x9 window consistency boost unit.
// ----------------------------------------------------------------------------
// Pixels are streamed image by image. Each accepted pixel goes through a
// behavioral model of the line store and the window, and any result item it
// completes is queued and compared field by field with the result items of the
// unit. A table of directed images comes first: reset size, size writes in the
// middle of an image, saturated sizes, both extreme sizes, flat images and
// pixel values at the match thresholds. Random images of small sizes follow.
// Both channels idle at random, and the result side is held off once for a
// long stretch so that the unit has to stall its input.
// ----------------------------------------------------------------------------
module window_consistency_boost_unit_tb;
    import wcb_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int LIMIT_NS       = 30_000_000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_COL       = 500;
    localparam int MAX_REPORTS    = 100;
    localparam int RANDOM_ITEMS   = 400;
    localparam int RANDOM_RESULTS = 60;
    localparam int CALM_SIZE      = 4000;
    localparam int RAND_MAX_H     = 14;

    typedef enum int {
        PAT_FLAT,
        PAT_LEVELS,
        PAT_SPARSE,
        PAT_NOISE,
        PAT_CLUSTER
    } pixel_pattern_e;

    // A pixel count of zero means one whole image at the current size, and a
    // boosted value of -1 leaves the expected value to the model.
    typedef struct packed {
        bit                    write_w;
        logic [CFG_DATA_W-1:0] w_data;
        bit                    write_h;
        logic [CFG_DATA_W-1:0] h_data;
        pixel_pattern_e        pat;
        int unsigned           level;
        int unsigned           n_pixels;
        int                    boost;
    } image_step_t;

    localparam int N_STEPS = 11;
    localparam image_step_t DIRECTED [N_STEPS] = '{
        // Reset size 640 x 480, stopped just after the first results.
        '{1'b0, 13'd0, 1'b0, 13'd0, PAT_FLAT, 7, 8 * 640 + 16, 7},
        // Width shrinks below the column count, so the line wraps early.
        '{1'b1, 13'd9, 1'b1, 13'd12, PAT_FLAT, 7, 28, 7},
        '{1'b1, 13'd16, 1'b1, 13'd12, PAT_FLAT, 0, 0, 0},
        '{1'b0, 13'd0, 1'b0, 13'd0, PAT_FLAT, 65535, 0, 65535},
        '{1'b0, 13'd0, 1'b0, 13'd0, PAT_LEVELS, 0, 0, -1},
        '{1'b0, 13'd0, 1'b0, 13'd0, PAT_SPARSE, 20000, 0, -1},
        // Both sizes saturate up to the smallest image.
        '{1'b1, 13'd0, 1'b1, 13'd0, PAT_FLAT, 300, 0, 300},
        // Widest image; the width field is masked and then saturated.
        '{1'b1, 13'h1FFF, 1'b1, 13'd4, PAT_CLUSTER, 1500, 0, -1},
        // Tallest image; the upper data bits of the width are dropped.
        '{1'b1, 13'h1809, 1'b1, 13'h1FFF, PAT_NOISE, 0, 0, -1},
        '{1'b1, 13'd12, 1'b1, 13'd20, PAT_CLUSTER, 40000, 12 * 11 + 5, -1},
        // Height shrinks below the current line, which then wraps to zero.
        '{1'b0, 13'd0, 1'b1, 13'd10, PAT_CLUSTER, 40000, 127, -1}
    };

    localparam logic [AMP_W-1:0] AMP_LEVELS [14] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd500, 16'd999, 16'd1000, 16'd1001,
        16'd2000, 16'd2001, 16'd32767, 16'd32768, 16'd65534, 16'd65535
    };

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    logic [AMP_W-1:0]      i_amplitude = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    logic [AMP_W-1:0]      o_boosted;
    logic [ROW_W-1:0]      o_out_row;
    logic [COL_W-1:0]      o_out_col;
    logic                  o_last_pixel;

    // Model state: line memory, window, raster position and image size.
    bit [AMP_W-1:0] line_mem [NLINES][MAX_COLS];
    bit [AMP_W-1:0] win_px [WSIZE][WSIZE];
    int unsigned    next_row   = 0;
    int unsigned    next_col   = 0;
    int unsigned    img_width  = RESET_WIDTH;
    int unsigned    img_height = RESET_HEIGHT;

    t_result     boost_queue [$];
    int unsigned predicted_count = 0;
    int unsigned error_count     = 0;
    bit          quiet_phase     = 1'b0;
    bit          hold_armed      = 1'b0;
    bit          hold_done       = 1'b0;

    window_consistency_boost_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_amplitude  (i_amplitude),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_boosted    (o_boosted),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_last_pixel (o_last_pixel)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
    endtask

    function automatic int unsigned gap_cycles();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            return 0;
        end
        if (roll < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [AMP_W-1:0] gen_pixel(input pixel_pattern_e pat,
                                                   input int unsigned level);
        longint unsigned scaled;
        case (pat)
            PAT_FLAT: begin
                return AMP_W'(level);
            end
            PAT_LEVELS: begin
                return AMP_LEVELS[$urandom_range(0, 13)];
            end
            PAT_NOISE: begin
                return AMP_W'($urandom_range(0, 65535));
            end
            default: begin
                if (pat == PAT_SPARSE && $urandom_range(0, 2) == 0) begin
                    return '0;
                end
                // Values scattered around the level give match counts of all sizes.
                scaled = level;
                scaled = scaled * $urandom_range(30, 260) / 100;
                return (scaled > 65535) ? 16'hFFFF : AMP_W'(scaled);
            end
        endcase
    endfunction

    function automatic void apply_size_reg(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        int unsigned v;
        if (idx == CFG_IDX_WIDTH) begin
            v = data[CFG_WID_W-1:0];
            img_width = (v < WSIZE) ? WSIZE : ((v > MAX_COLS) ? MAX_COLS : v);
        end else begin
            v = data[CFG_HGT_W-1:0];
            img_height = (v < WSIZE) ? WSIZE : ((v > MAX_ROWS) ? MAX_ROWS : v);
        end
    endfunction

    task automatic predict_boost(input logic [AMP_W-1:0] pix, output bit emitted,
                                 output t_result res);
        int unsigned     r, c, col_idx, k, j;
        longint unsigned centre, hits, px;
        r = next_row;
        c = next_col;
        col_idx = (c < MAX_COLS) ? c : MAX_COLS - 1;
        // The window moves one column left; the new column is the stored lines,
        // oldest on top, with the incoming pixel at the bottom.
        for (k = 0; k < WSIZE; k++) begin
            for (j = 0; j < WSIZE - 1; j++) begin
                win_px[k][j] = win_px[k][j + 1];
            end
        end
        for (k = 0; k < NLINES; k++) begin
            win_px[k][WSIZE - 1] = line_mem[(r + k) % NLINES][col_idx];
        end
        win_px[WSIZE - 1][WSIZE - 1] = pix;
        line_mem[r % NLINES][col_idx] = pix;

        emitted = 1'b0;
        res = '0;
        if (r >= NLINES && c >= NLINES && r < img_height && c < img_width) begin
            centre = win_px[WINDOW_RADIUS][WINDOW_RADIUS];
            hits = 0;
            if (centre != 0) begin
                for (k = 0; k < WSIZE; k++) begin
                    for (j = 0; j < WSIZE; j++) begin
                        px = win_px[k][j];
                        if (px + px >= centre && px <= centre + centre) begin
                            hits++;
                        end
                    end
                end
            end
            res.boosted = AMP_W'(centre * hits / (WSIZE * WSIZE));
            res.row     = ROW_W'(r - WINDOW_RADIUS);
            res.col     = COL_W'(c - WINDOW_RADIUS);
            res.last    = (r == img_height - 1) && (c == img_width - 1);
            emitted = 1'b1;
        end

        if (c + 1 >= img_width) begin
            next_col = 0;
            next_row = (r + 1 >= img_height) ? 0 : (r + 1) % MAX_ROWS;
        end else begin
            next_col = (c + 1) % MAX_COLS;
        end
    endtask

    task automatic send_pixel(input logic [AMP_W-1:0] pix, input int boost_override);
        int unsigned gap;
        bit          emitted;
        t_result     res;
        gap = quiet_phase ? 0 : gap_cycles();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_amplitude <= pix;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_boost(pix, emitted, res);
        if (emitted) begin
            if (boost_override >= 0) begin
                res.boosted = AMP_W'(boost_override);
            end
            boost_queue.push_back(res);
            predicted_count++;
        end
    endtask

    task automatic run_pixels(input pixel_pattern_e pat, input int unsigned level,
                              input int unsigned count, input int boost_override);
        repeat (count) send_pixel(gen_pixel(pat, level), boost_override);
    endtask

    // Pixels that complete no window may still be in the pipeline when the
    // queue runs empty, hence the extra cycles.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (boost_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_size(input bit do_w, input logic [CFG_DATA_W-1:0] w_data,
                                input bit do_h, input logic [CFG_DATA_W-1:0] h_data);
        if (do_w) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_WIDTH;
            i_cfg_data  <= w_data;
            @(posedge i_clk);
            apply_size_reg(CFG_IDX_WIDTH, w_data);
        end
        if (do_h) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_HEIGHT;
            i_cfg_data  <= h_data;
            @(posedge i_clk);
            apply_size_reg(CFG_IDX_HEIGHT, h_data);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold once results run densely.
    initial begin : result_ready
        int unsigned stall;
        forever begin
            @(posedge i_clk);
            stall = quiet_phase ? 0 : gap_cycles();
            if (hold_armed) begin
                hold_armed = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_boost
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_boosted, o_out_row, o_out_col, o_last_pixel};
            if (boost_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected item boosted=%0d row=%0d col=%0d last=%0b",
                                          got.boosted, got.row, got.col, got.last));
            end else begin
                want = boost_queue.pop_front();
                if (got.boosted !== want.boosted || got.row !== want.row ||
                    got.col !== want.col || got.last !== want.last) begin
                    report_mismatch($sformatf(
                        "got boosted=%0d row=%0d col=%0d last=%0b, want %0d %0d %0d %0b",
                        got.boosted, got.row, got.col, got.last,
                        want.boosted, want.row, want.col, want.last));
                end
            end
            if (got.col == HOLD_COL && !hold_done) begin
                hold_done  = 1'b1;
                hold_armed = 1'b1;
            end
        end
    end

    initial begin : stimulus
        image_step_t    step;
        pixel_pattern_e pat;
        int unsigned    count, level, split, roll;
        int unsigned    rnd_items, rnd_base;
        bit             do_w, do_h;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        for (int s = 0; s < N_STEPS; s++) begin
            step = DIRECTED[s];
            if (step.write_w || step.write_h) begin
                wait_drained();
                program_size(step.write_w, step.w_data, step.write_h, step.h_data);
            end
            count = (step.n_pixels == 0) ? img_width * img_height : step.n_pixels;
            quiet_phase = (count > CALM_SIZE);
            run_pixels(step.pat, step.level, count, step.boost);
        end

        // Random images, mostly small; each runs to its end so that the next
        // one starts from the first line.
        rnd_items = 0;
        rnd_base  = predicted_count;
        while (rnd_items < RANDOM_ITEMS || predicted_count - rnd_base < RANDOM_RESULTS) begin
            do_w = ($urandom_range(0, 3) != 0);
            do_h = ($urandom_range(0, 3) != 0);
            if (do_w || do_h) begin
                wait_drained();
                program_size(do_w, ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                                              : $urandom_range(WSIZE, 24),
                             do_h, $urandom_range(WSIZE, RAND_MAX_H));
            end
            quiet_phase = ($urandom_range(0, 3) == 0);
            roll  = $urandom_range(0, 99);
            pat   = (roll < 60) ? PAT_CLUSTER : (roll < 75) ? PAT_LEVELS :
                    (roll < 85) ? PAT_SPARSE : (roll < 95) ? PAT_NOISE : PAT_FLAT;
            level = $urandom_range(1, 65535);
            count = img_width * img_height;
            if ($urandom_range(0, 4) == 0) begin
                // Size change in mid-image: the width only shrinks, so every
                // window still reads lines that were written.
                split = $urandom_range(1, count - 1);
                run_pixels(pat, level, split, -1);
                rnd_items += split;
                wait_drained();
                program_size($urandom_range(0, 1), $urandom_range(WSIZE, img_width),
                             1'b1, $urandom_range(WSIZE, RAND_MAX_H));
                do begin
                    send_pixel(gen_pixel(pat, level), -1);
                    rnd_items++;
                end while (next_row != 0 || next_col != 0);
            end else begin
                run_pixels(pat, level, count, -1);
                rnd_items += count;
            end
        end

        wait_drained();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
